// ===== hw/rtl/fbpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared constants, item codes and the queue entry type.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MaxBlocks = 256;
    localparam int CountW    = $clog2(MaxBlocks + 1);
    localparam int IdxW      = $clog2(MaxBlocks);
    localparam int UsedW     = 25;

    typedef enum logic [1:0] {
        KIND_ALLOC    = 2'd0,
        KIND_FREE     = 2'd1,
        KIND_RESET    = 2'd2,
        KIND_CONTAINS = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NULL      = 2'd1,
        ST_FAIL      = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_BASE  = 2'd0,
        CFG_BLOCK = 2'd1,
        CFG_ALIGN = 2'd2,
        CFG_COUNT = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_FILL,
        BK_MOD,
        BK_OUT
    } bk_state_t;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        kind_t       kind;
        logic        zero_size;
        logic        too_big;
        logic        null_ptr;
        logic [31:0] address;
    } item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fbpa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts items, compares them against the configuration and queues them.
// ----------------------------------------------------------------------------
module fbpa_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      kind,
    input  wire logic [31:0]     size_bytes,
    input  wire logic [4:0]      req_align_log2,
    input  wire logic [31:0]     address,
    input  wire logic            null_pointer,
    input  wire logic [16:0]     block_bytes,
    input  wire logic [3:0]      align_log2,
    output logic                 q_valid,
    output fbpa_pkg::item_t      q_item,
    input  wire logic            q_pop
);

    // Two-entry queue.
    fbpa_pkg::item_t mem_reg [2];
    logic            rd_ptr_reg, rd_ptr_next;
    logic            wr_ptr_reg, wr_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    fbpa_pkg::item_t item_in;
    logic            push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.kind      = fbpa_pkg::kind_t'(kind);
        item_in.zero_size = (size_bytes == 32'd0);
        item_in.too_big   = (size_bytes > {15'd0, block_bytes})
                            || (req_align_log2 > {1'b0, align_log2});
        item_in.null_ptr  = null_pointer;
        item_in.address   = address;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fbpa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Executes queued items on the free stack and keeps the statistics.
// ----------------------------------------------------------------------------
module fbpa_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire fbpa_pkg::item_t               q_item,
    output logic                               q_pop,
    input  wire logic [31:0]                   base_address,
    input  wire logic [16:0]                   block_bytes,
    input  wire logic [8:0]                    blocks_in_use,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         status,
    output logic [31:0]                        block_address,
    output logic                               contained,
    output logic [8:0]                         free_blocks,
    output logic [24:0]                        used_bytes,
    output logic [24:0]                        peak_bytes,
    output logic [8:0]                         live_allocs,
    output logic [31:0]                        total_allocs,
    output logic [31:0]                        total_frees,
    output logic [31:0]                        failed_allocs
);

    localparam int CW = fbpa_pkg::CountW;
    localparam int IW = fbpa_pkg::IdxW;
    localparam logic [24:0] UsedMax = '1;

    logic [31:0] stack_mem [fbpa_pkg::MaxBlocks];
    logic [31:0] rd_data_reg;

    fbpa_pkg::bk_state_t state_reg, state_next;
    fbpa_pkg::item_t     cur_reg;
    logic [CW-1:0]       free_cnt_reg;
    logic [24:0]         used_reg;
    logic [24:0]         peak_reg;
    logic [8:0]          live_reg;
    logic [31:0]         allocs_reg;
    logic [31:0]         frees_reg;
    logic [31:0]         fails_reg;
    logic [CW-1:0]       fill_idx_reg;
    logic [31:0]         fill_addr_reg;
    logic [48:0]         rem_reg;
    logic [48:0]         div_reg;
    logic [5:0]          div_step_reg;
    logic                in_range_reg;
    logic [CW-1:0]       pool_n;
    logic [48:0]         pool_end;
    logic                alloc_ok;
    logic                free_ok;
    logic                take;
    logic [25:0]         used_sum;

    assign pool_n = (blocks_in_use > 9'(fbpa_pkg::MaxBlocks)) ? CW'(fbpa_pkg::MaxBlocks)
                                                              : CW'(blocks_in_use);
    assign pool_end = {17'd0, base_address} + 49'(block_bytes) * 49'(pool_n);
    assign alloc_ok = !cur_reg.zero_size && !cur_reg.too_big && (free_cnt_reg != '0);
    assign free_ok  = !cur_reg.null_ptr && (free_cnt_reg != CW'(fbpa_pkg::MaxBlocks));
    assign take     = (state_reg == fbpa_pkg::BK_IDLE) && q_valid;
    assign used_sum = {1'b0, used_reg} + 26'(block_bytes);
    assign q_pop    = take;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbpa_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        fbpa_pkg::KIND_RESET:    state_next = fbpa_pkg::BK_FILL;
                        fbpa_pkg::KIND_CONTAINS: state_next = fbpa_pkg::BK_MOD;
                        default:                 state_next = fbpa_pkg::BK_READ;
                    endcase
                end
            end
            fbpa_pkg::BK_READ: state_next = fbpa_pkg::BK_OUT;
            fbpa_pkg::BK_FILL:
            begin
                if (fill_idx_reg == pool_n)
                begin
                    state_next = fbpa_pkg::BK_OUT;
                end
            end
            fbpa_pkg::BK_MOD:
            begin
                if (div_step_reg == 6'd0)
                begin
                    state_next = fbpa_pkg::BK_OUT;
                end
            end
            fbpa_pkg::BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = fbpa_pkg::BK_IDLE;
                end
            end
            default: state_next = fbpa_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid = (state_reg == fbpa_pkg::BK_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fbpa_pkg::BK_IDLE;
            free_cnt_reg <= '0;
            used_reg     <= '0;
            peak_reg     <= '0;
            live_reg     <= '0;
            allocs_reg   <= '0;
            frees_reg    <= '0;
            fails_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fbpa_pkg::BK_READ)
            begin
                if (cur_reg.kind == fbpa_pkg::KIND_ALLOC)
                begin
                    if (!cur_reg.zero_size && !alloc_ok)
                    begin
                        fails_reg <= fails_reg + 32'd1;
                    end
                    else if (alloc_ok)
                    begin
                        free_cnt_reg <= free_cnt_reg - CW'(1);
                        used_reg     <= used_sum[25] ? UsedMax : used_sum[24:0];
                        if ((used_sum[25] ? UsedMax : used_sum[24:0]) > peak_reg)
                        begin
                            peak_reg <= used_sum[25] ? UsedMax : used_sum[24:0];
                        end
                        live_reg   <= live_reg + 9'd1;
                        allocs_reg <= allocs_reg + 32'd1;
                    end
                end
                else if (free_ok)
                begin
                    free_cnt_reg <= free_cnt_reg + CW'(1);
                    used_reg     <= (used_reg > 25'(block_bytes))
                                    ? used_reg - 25'(block_bytes) : 25'd0;
                    live_reg     <= live_reg - 9'd1;
                    frees_reg    <= frees_reg + 32'd1;
                end
            end
            if ((state_reg == fbpa_pkg::BK_FILL) && (fill_idx_reg == pool_n))
            begin
                free_cnt_reg <= pool_n;
                used_reg     <= '0;
                live_reg     <= '0;
            end
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if ((state_reg == fbpa_pkg::BK_READ) && (cur_reg.kind == fbpa_pkg::KIND_FREE)
            && free_ok)
        begin
            stack_mem[free_cnt_reg[IW-1:0]] <= cur_reg.address;
        end
        else if ((state_reg == fbpa_pkg::BK_FILL) && (fill_idx_reg != pool_n))
        begin
            stack_mem[fill_idx_reg[IW-1:0]] <= fill_addr_reg;
        end
        if (take)
        begin
            rd_data_reg <= stack_mem[IW'(free_cnt_reg - CW'(1))];
        end
    end

    // Datapath: item capture, fill walk, restoring remainder and result.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg       <= q_item;
            fill_idx_reg  <= '0;
            fill_addr_reg <= base_address;
            rem_reg       <= 49'(q_item.address - base_address);
            div_reg       <= {block_bytes, 32'd0};
            div_step_reg  <= 6'd32;
            in_range_reg  <= !q_item.null_ptr && (block_bytes != 17'd0) && (pool_n != '0)
                             && (q_item.address >= base_address)
                             && ({17'd0, q_item.address} < pool_end);
        end
        if (state_reg == fbpa_pkg::BK_FILL)
        begin
            fill_idx_reg  <= fill_idx_reg + CW'(1);
            fill_addr_reg <= fill_addr_reg + 32'(block_bytes);
        end
        if (state_reg == fbpa_pkg::BK_MOD)
        begin
            if (rem_reg >= div_reg)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            div_reg      <= div_reg >> 1;
            div_step_reg <= div_step_reg - 6'd1;
        end
        if ((state_reg == fbpa_pkg::BK_READ) || (state_reg == fbpa_pkg::BK_FILL)
            || (state_reg == fbpa_pkg::BK_MOD))
        begin
            status        <= fbpa_pkg::ST_OK;
            block_address <= 32'd0;
            contained     <= 1'b0;
            if (state_reg == fbpa_pkg::BK_READ)
            begin
                if (cur_reg.kind == fbpa_pkg::KIND_ALLOC)
                begin
                    if (cur_reg.zero_size)
                    begin
                        status <= fbpa_pkg::ST_NULL;
                    end
                    else if (!alloc_ok)
                    begin
                        status <= fbpa_pkg::ST_FAIL;
                    end
                    else
                    begin
                        block_address <= rd_data_reg;
                    end
                end
                else if (cur_reg.null_ptr)
                begin
                    status <= fbpa_pkg::ST_NULL;
                end
                else if (!free_ok)
                begin
                    status <= fbpa_pkg::ST_FULL;
                end
            end
            if (state_reg == fbpa_pkg::BK_MOD)
            begin
                // The remainder after this cycle's subtract step decides the answer.
                contained <= in_range_reg
                             && (((rem_reg >= div_reg) ? rem_reg - div_reg : rem_reg)
                                 == 49'd0);
            end
        end
    end

    assign free_blocks   = 9'(free_cnt_reg);
    assign used_bytes    = used_reg;
    assign peak_bytes    = peak_reg;
    assign live_allocs   = live_reg;
    assign total_allocs  = allocs_reg;
    assign total_frees   = frees_reg;
    assign failed_allocs = fails_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_block_pool_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Free-list allocator for equal blocks with usage statistics.
// ----------------------------------------------------------------------------
// Allocate and free items pass from the front queue through the read state,
// which uses the registered read of the free stack memory, to the output
// state; a two-entry queue lets the front take items while the back works.
// A reset item walks the stack memory one entry a cycle up to the block
// count, capped at 256, before it answers; a contains query runs a
// bit-serial remainder. Issue a reset item after configuring the block.
module fixed_block_pool_allocator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] size_bytes,
    input  wire logic [4:0]  req_align_log2,
    input  wire logic [31:0] address,
    input  wire logic        null_pointer,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      block_address,
    output logic             contained,
    output logic [8:0]       free_blocks,
    output logic [24:0]      used_bytes,
    output logic [24:0]      peak_bytes,
    output logic [8:0]       live_allocs,
    output logic [31:0]      total_allocs,
    output logic [31:0]      total_frees,
    output logic [31:0]      failed_allocs
);

    logic [31:0]     base_reg;
    logic [16:0]     block_reg;
    logic [3:0]      align_reg;
    logic [8:0]      count_reg;
    logic            q_valid;
    logic            q_pop;
    fbpa_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            block_reg <= '0;
            align_reg <= '0;
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (fbpa_pkg::cfg_index_t'(cfg_index))
                fbpa_pkg::CFG_BASE:  base_reg  <= cfg_data;
                fbpa_pkg::CFG_BLOCK: block_reg <= cfg_data[16:0];
                fbpa_pkg::CFG_ALIGN: align_reg <= cfg_data[3:0];
                fbpa_pkg::CFG_COUNT: count_reg <= cfg_data[8:0];
                default:             base_reg  <= base_reg;
            endcase
        end
    end

    fbpa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .size_bytes     (size_bytes),
        .req_align_log2 (req_align_log2),
        .address        (address),
        .null_pointer   (null_pointer),
        .block_bytes    (block_reg),
        .align_log2     (align_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    fbpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .base_address  (base_reg),
        .block_bytes   (block_reg),
        .blocks_in_use (count_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_address (block_address),
        .contained     (contained),
        .free_blocks   (free_blocks),
        .used_bytes    (used_bytes),
        .peak_bytes    (peak_bytes),
        .live_allocs   (live_allocs),
        .total_allocs  (total_allocs),
        .total_frees   (total_frees),
        .failed_allocs (failed_allocs)
    );

endmodule
`default_nettype wire
